// ===== design/utf8d_pkg.sv =====
// utf8d_pkg: types and constants shared by the UTF-8 decoder with Latin-1 fallback.
// Holds the job record that passes from the front end to the result stage.
// No dependencies.
package utf8d_pkg;

	localparam int CpW    = 21;
	localparam int ByteW  = 8;
	localparam int MaxRes = 4;

	typedef logic [CpW-1:0]   cp_t;
	typedef logic [ByteW-1:0] byte_t;

	// One job: up to four results caused by a single input byte
	typedef struct packed {
		logic [2:0]              cnt;
		logic [MaxRes-1:0]       seq;
		cp_t  [MaxRes-1:0]       cp;
	} job_t;

	// Lead byte ranges
	localparam byte_t Lead4Lo = 8'hF0;
	localparam byte_t Lead4Hi = 8'hF4;
	localparam byte_t Lead3Lo = 8'hE0;
	localparam byte_t Lead3Hi = 8'hEF;
	localparam byte_t Lead2Lo = 8'hC2;
	localparam byte_t Lead2Hi = 8'hDF;

	// Continuation test: (b & ContMask) == ContTag
	localparam byte_t ContMask = 8'hC0;
	localparam byte_t ContTag  = 8'h80;

	// Validity limits on decoded scalars
	localparam cp_t Min3    = 21'h000800;
	localparam cp_t Min4    = 21'h010000;
	localparam cp_t SurrLo  = 21'h00D800;
	localparam cp_t SurrHi  = 21'h00DFFF;
	localparam cp_t CpMax   = 21'h10FFFF;

	// Continuations needed by a lead byte
	localparam logic [1:0] NeedNone = 2'd0;
	localparam logic [1:0] NeedOne  = 2'd1;
	localparam logic [1:0] NeedTwo  = 2'd2;
	localparam logic [1:0] NeedThree = 2'd3;

endpackage

// ===== design/utf8d_front.sv =====
// utf8d_front: accepts text bytes, keeps the pending sequence, classifies each byte
// and builds the job of results it causes.
// Depends on utf8d_pkg.
module utf8d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  utf8d_pkg::byte_t  text_byte,
	output logic              job_push,
	output utf8d_pkg::job_t   job
);
	import utf8d_pkg::*;

	byte_t      held_q [3];
	byte_t      held_d [3];
	logic [1:0] cnt_q, cnt_d;
	logic [1:0] len_q, len_d;
	logic       is_cont;
	logic [1:0] need_new;
	cp_t        v;
	logic       ok;

	assign is_cont = (text_byte & ContMask) == ContTag;

	always_comb begin
		if (text_byte >= Lead4Lo && text_byte <= Lead4Hi) begin
			need_new = NeedThree;
		end else if (text_byte >= Lead3Lo && text_byte <= Lead3Hi) begin
			need_new = NeedTwo;
		end else if (text_byte >= Lead2Lo && text_byte <= Lead2Hi) begin
			need_new = NeedOne;
		end else begin
			need_new = NeedNone;
		end
	end

	// Assemble the scalar as if this byte completes the held sequence
	always_comb begin
		case (len_q)
			NeedOne: begin
				v = {10'd0, held_q[0][4:0], text_byte[5:0]};
				ok = 1'b1;
			end
			NeedTwo: begin
				v = {5'd0, held_q[0][3:0], held_q[1][5:0], text_byte[5:0]};
				ok = (v >= Min3) && !(v >= SurrLo && v <= SurrHi);
			end
			NeedThree: begin
				v = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], text_byte[5:0]};
				ok = (v >= Min4) && (v <= CpMax);
			end
			default: begin
				v = '0;
				ok = 1'b1;
			end
		endcase
	end

	always_comb begin
		held_d = held_q;
		cnt_d  = cnt_q;
		len_d  = len_q;
		job.seq = '0;
		// Fallback layout: held bytes in order, the new byte just after them
		job.cp[0] = {13'd0, (cnt_q == 2'd0) ? text_byte : held_q[0]};
		job.cp[1] = {13'd0, (cnt_q == 2'd1) ? text_byte : held_q[1]};
		job.cp[2] = {13'd0, (cnt_q == 2'd2) ? text_byte : held_q[2]};
		job.cp[3] = {13'd0, text_byte};
		job.cnt   = 3'd0;
		if (cnt_q != 2'd0 && is_cont) begin
			if (cnt_q == len_q) begin
				if (ok) begin
					job.cnt    = 3'd1;
					job.cp[0]  = v;
					job.seq[0] = 1'b1;
				end else begin
					job.cnt = {1'b0, cnt_q} + 3'd1;
				end
				cnt_d = 2'd0;
				len_d = NeedNone;
			end else begin
				case (cnt_q)
					2'd1: held_d[1] = text_byte;
					2'd2: held_d[2] = text_byte;
					default: ;
				endcase
				cnt_d = cnt_q + 2'd1;
			end
		end else begin
			// flush anything held, then treat the byte afresh
			job.cnt = {1'b0, cnt_q};
			cnt_d   = 2'd0;
			len_d   = NeedNone;
			if (text_byte != '0) begin
				if (need_new != NeedNone) begin
					held_d[0] = text_byte;
					cnt_d     = 2'd1;
					len_d     = need_new;
				end else begin
					job.cnt = {1'b0, cnt_q} + 3'd1;
				end
			end
		end
	end

	assign job_push = acc && (job.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			len_q <= NeedNone;
		end else if (acc) begin
			cnt_q <= cnt_d;
			len_q <= len_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			held_q <= held_d;
		end
	end

endmodule

// ===== design/utf8d_queue.sv =====
// utf8d_queue: short job queue between the front end and the result stage.
// Depends on utf8d_pkg.
module utf8d_queue #(
	parameter int Depth = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  utf8d_pkg::job_t  wr_job,
	input  logic             pop,
	output utf8d_pkg::job_t  rd_job,
	output logic             full,
	output logic             empty
);
	import utf8d_pkg::*;

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	job_t          mem_q [Depth];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full   = count_q == CW'(Depth);
	assign empty  = count_q == '0;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== design/utf8d_back.sv =====
// utf8d_back: walks the head job one result per cycle into the output register
// when that register is empty or popped. Depends on utf8d_pkg.
module utf8d_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  utf8d_pkg::job_t  head_job,
	output logic             head_pop,
	input  logic             pop,
	output logic             empty,
	output utf8d_pkg::cp_t   code_point,
	output logic             from_sequence,
	output logic             last_of_run
);
	import utf8d_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	cp_t        cp_q;
	logic       seq_q, last_q;
	logic       load, at_last;

	assign load     = head_valid && (!out_valid_q || pop);
	assign at_last  = idx_q == 2'(head_job.cnt - 3'd1);
	assign head_pop = load && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= at_last ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q   <= head_job.cp[idx_q];
			seq_q  <= head_job.seq[idx_q];
			last_q <= at_last;
		end
	end

	assign empty         = !out_valid_q;
	assign code_point    = cp_q;
	assign from_sequence = seq_q;
	assign last_of_run   = last_q;

endmodule

// ===== design/utf8_decoder_latin1_fallback_core.sv =====
// utf8_decoder_latin1_fallback_core: streaming UTF-8 decoder, Latin-1 fallback.
// Top level; instantiates utf8d_front, utf8d_queue and utf8d_back, uses utf8d_pkg.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------------
//   input    | push / full        | text_byte[7:0]
//   result   | empty / pop        | code_point[20:0], from_sequence, last_of_run
//
// The front end takes one byte per cycle while the job queue has room; each byte
// turns into a job of zero to four results in the same cycle; empty jobs are not queued.
// The result stage issues one result per cycle while the result side keeps popping;
// bursts of fallback output are soaked up by the job queue.
// Each result is held in the job queue and then in the output register before it appears.
// Reset (arst_n low) drops the pending sequence, all queued jobs and the result.
// full follows the job queue alone; a stalled result side backs up into it.
module utf8_decoder_latin1_fallback_core #(
	parameter int QueueDepth = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  utf8d_pkg::byte_t      text_byte,
	output logic                  empty,
	input  logic                  pop,
	output utf8d_pkg::cp_t        code_point,
	output logic                  from_sequence,
	output logic                  last_of_run
);
	import utf8d_pkg::*;

	logic acc;        // input transaction this cycle
	logic job_push;   // the byte produced at least one result
	job_t new_job;
	job_t head_job;
	logic q_full, q_empty, q_pop;

	assign acc  = push && !q_full;
	assign full = q_full;

	// Front: pending-sequence tracking and classification
	utf8d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.text_byte (text_byte),
		.job_push  (job_push),
		.job       (new_job)
	);

	// Decoupling queue of jobs
	utf8d_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wr_job (new_job),
		.pop    (q_pop),
		.rd_job (head_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Back: one result per transaction on the result side
	utf8d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (!q_empty),
		.head_job      (head_job),
		.head_pop      (q_pop),
		.pop           (pop),
		.empty         (empty),
		.code_point    (code_point),
		.from_sequence (from_sequence),
		.last_of_run   (last_of_run)
	);

`ifndef SYNTHESIS
	// A decoded sequence is always the only result of its byte
	a_seq_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && from_sequence |-> last_of_run)
		else $error("decoded scalar not marked last of run");

	// Decoded scalars are multi-byte and in range
	a_seq_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && from_sequence |-> (code_point >= 21'h80 && code_point <= CpMax))
		else $error("decoded scalar out of range");

	// Fallback results are single bytes
	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !from_sequence |-> code_point[20:8] == '0)
		else $error("fallback result wider than a byte");

	// No job is written into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !q_full)
		else $error("job queue overflow");
`endif

endmodule
